@@ hdl/sbc_pkg.sv @@
// Shared types, constants and tables for the scan beam clusterer.
package sbc_pkg;

    localparam int DEF_MAX_BEAMS    = 1024;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int DIV_STEPS        = 31;

    localparam logic [10:0] POINT_CAP = 11'd2047;
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
    localparam logic [23:0] GAIN_Q24 = 24'd10188014;

    typedef enum logic [2:0] {
        REG_LOWER = 3'd0,
        REG_UPPER = 3'd1,
        REG_START = 3'd2,
        REG_STEP  = 3'd3,
        REG_JOIN  = 3'd4,
        REG_LEAST = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] lower;
        logic [15:0] upper;
        logic [15:0] start;
        logic [15:0] step;
        logic [15:0] join_dist;
        logic [12:0] least;
    } t_cfg;

    // one cluster to be reduced to a landmark
    typedef struct packed {
        logic               last;
        logic [10:0]        count;
        logic signed [27:0] sum_e;
        logic signed [27:0] sum_n;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE, F_ROT, F_MUL, F_DIST, F_DEC, F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_VEC, B_MUL1, B_MUL2, B_DIV, B_OUT
    } t_bstate;

    // arctan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/scan_beam_clusterer.sv @@
// Top level of the scan beam clusterer: config registers, front, queue, back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  beam    | in        | i_in_valid / o_in_stall    | i_range_sample, i_end_of_scan
//  result  | out       | o_out_valid / i_out_stall  | o_landmark_range, _bearing, o_last_of_item
//  config  | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A valid beam runs the rotation CORDIC in the front (one step a cycle), then the point
// multiply, distance and decision states; an out-of-range beam goes straight to decision.
// Jobs are pushed while the queue is not full. Each landmark in the back passes the
// vectoring CORDIC, a two-part gain multiply and a 31-step restoring divide by the point count.
// A four-entry job queue lets the front take beams while the back still works.
// Reset is synchronous, active low, and restores register defaults and empty clusters.
// The output register holds a stalled transaction; the back waits, then the queue fills.
module scan_beam_clusterer #(
    parameter int MAX_BEAMS    = sbc_pkg::DEF_MAX_BEAMS,
    parameter int CORDIC_STEPS = sbc_pkg::DEF_CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_range_sample,
    input  logic               i_end_of_scan,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_landmark_range,
    output logic signed [15:0] o_landmark_bearing,
    output logic               o_last_of_item
);
    sbc_pkg::t_cfg r_cfg;
    logic          push, pop, q_full, q_valid;
    sbc_pkg::t_job push_job, pop_job;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower     <= 16'd120;
            r_cfg.upper     <= 16'd3500;
            r_cfg.start     <= 16'd0;
            r_cfg.step      <= 16'd182;
            r_cfg.join_dist <= 16'd300;
            r_cfg.least     <= 13'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbc_pkg::REG_LOWER: r_cfg.lower     <= i_cfg_data;
                sbc_pkg::REG_UPPER: r_cfg.upper     <= i_cfg_data;
                sbc_pkg::REG_START: r_cfg.start     <= i_cfg_data;
                sbc_pkg::REG_STEP:  r_cfg.step      <= i_cfg_data;
                sbc_pkg::REG_JOIN:  r_cfg.join_dist <= i_cfg_data;
                sbc_pkg::REG_LEAST: r_cfg.least     <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    sbc_front #(
        .MAX_BEAMS    (MAX_BEAMS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_range_sample (i_range_sample),
        .i_end_of_scan  (i_end_of_scan),
        .o_push         (push),
        .o_push_job     (push_job),
        .i_q_full       (q_full)
    );

    sbc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_job      (pop_job)
    );

    sbc_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_job              (pop_job),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_landmark_range   (o_landmark_range),
        .o_landmark_bearing (o_landmark_bearing),
        .o_last_of_item     (o_last_of_item)
    );

endmodule

@@ hdl/sbc_front.sv @@
// Front end: beam to point conversion, cluster bookkeeping, job issue.
module sbc_front #(
    parameter int MAX_BEAMS    = sbc_pkg::DEF_MAX_BEAMS,
    parameter int CORDIC_STEPS = sbc_pkg::DEF_CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbc_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_range_sample,
    input  logic               i_end_of_scan,
    output logic               o_push,
    output sbc_pkg::t_job      o_push_job,
    input  logic               i_q_full
);
    localparam int BW = $clog2(MAX_BEAMS);
    localparam int IW = $clog2(CORDIC_STEPS);

    sbc_pkg::t_fstate r_state, n_state;

    logic [BW-1:0]       r_bc;
    logic [15:0]         r_range;
    logic                r_eos, r_invalid, r_flip;
    logic [31:0]         r_z;
    logic signed [32:0]  r_x, r_y;
    logic [IW-1:0]       r_i;
    logic signed [17:0]  r_east, r_north, r_pe, r_pn;
    logic [37:0]         r_dx2, r_dy2;
    logic [31:0]         r_t2;
    logic [10:0]         r_pc;
    logic signed [27:0]  r_se, r_sn;
    sbc_pkg::t_job       r_jobs [2];
    logic [1:0]          r_jv;

    logic                accept;
    logic [31:0]         ang_prod;
    logic [15:0]         ang;
    logic [31:0]         z0;
    logic signed [32:0]  xs, ys, cval, sval;
    logic [31:0]         atan_v;
    logic signed [49:0]  pe_full, pn_full;
    logic signed [18:0]  dx, dy;
    logic signed [37:0]  dx_sq, dy_sq;
    logic [37:0]         d2;
    logic                split, yield_cur, yield_new;
    logic [10:0]         npc;
    logic signed [27:0]  nse, nsn;

    // ---------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbc_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != sbc_pkg::F_IDLE);
        o_push     = 1'b0;
        o_push_job = r_jv[0] ? r_jobs[0] : r_jobs[1];
        unique case (r_state)
            sbc_pkg::F_IDLE: begin
                if (i_in_valid) begin
                    n_state = ((i_range_sample < i_cfg.lower) ||
                               (i_range_sample > i_cfg.upper)) ?
                              sbc_pkg::F_DEC : sbc_pkg::F_ROT;
                end
            end
            sbc_pkg::F_ROT: begin
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    n_state = sbc_pkg::F_MUL;
                end
            end
            sbc_pkg::F_MUL:  n_state = sbc_pkg::F_DIST;
            sbc_pkg::F_DIST: n_state = sbc_pkg::F_DEC;
            sbc_pkg::F_DEC:  n_state = sbc_pkg::F_PUSH;
            sbc_pkg::F_PUSH: begin
                if (r_jv == 2'b00) begin
                    n_state = sbc_pkg::F_IDLE;
                end else begin
                    o_push = !i_q_full;
                end
            end
            default: n_state = sbc_pkg::F_IDLE;
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    // ---------------- datapath
    assign ang_prod = 32'(r_bc) * 32'(i_cfg.step);
    assign ang      = i_cfg.start + ang_prod[15:0];
    assign z0       = {ang, 16'h0000};

    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign atan_v = sbc_pkg::atan_lut(5'(r_i));

    assign cval    = r_flip ? -r_x : r_x;
    assign sval    = r_flip ? -r_y : r_y;
    assign pe_full = $signed({1'b0, r_range}) * cval + 50'sd536870912;
    assign pn_full = $signed({1'b0, r_range}) * sval + 50'sd536870912;

    assign dx    = r_east - r_pe;
    assign dy    = r_north - r_pn;
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign d2    = r_dx2 + r_dy2;

    assign split     = (r_pc != 11'd0) &&
                       ((d2 > {6'd0, r_t2}) || (r_pc >= sbc_pkg::POINT_CAP));
    assign yield_cur = (r_pc != 11'd0) && ({2'b00, r_pc} >= i_cfg.least);
    assign npc       = split ? 11'd1 : r_pc + 11'd1;
    assign yield_new = {2'b00, npc} >= i_cfg.least;
    assign nse = (split ? 28'sd0 : r_se) + {{10{r_east[17]}}, r_east};
    assign nsn = (split ? 28'sd0 : r_sn) + {{10{r_north[17]}}, r_north};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= '0;
            r_pc <= '0;
            r_se <= '0;
            r_sn <= '0;
            r_pe <= '0;
            r_pn <= '0;
            r_jv <= 2'b00;
        end else begin
            unique case (r_state)
                sbc_pkg::F_IDLE: begin
                    if (accept) begin
                        r_range   <= i_range_sample;
                        r_eos     <= i_end_of_scan;
                        r_invalid <= (i_range_sample < i_cfg.lower) ||
                                     (i_range_sample > i_cfg.upper);
                        r_flip    <= z0[31] ^ z0[30];
                        r_z       <= (z0[31] ^ z0[30]) ? z0 + 32'h80000000 : z0;
                        r_x       <= sbc_pkg::GAIN_Q30;
                        r_y       <= '0;
                        r_i       <= '0;
                    end
                end
                sbc_pkg::F_ROT: begin
                    if (!r_z[31]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_v;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_v;
                    end
                    r_i <= r_i + 1'b1;
                end
                sbc_pkg::F_MUL: begin
                    r_east  <= pe_full[47:30];
                    r_north <= pn_full[47:30];
                end
                sbc_pkg::F_DIST: begin
                    r_dx2 <= 38'(dx_sq);
                    r_dy2 <= 38'(dy_sq);
                    r_t2  <= 32'(i_cfg.join_dist) * 32'(i_cfg.join_dist);
                end
                sbc_pkg::F_DEC: begin
                    r_jobs[0].count <= r_pc;
                    r_jobs[0].sum_e <= r_se;
                    r_jobs[0].sum_n <= r_sn;
                    r_jobs[1].count <= npc;
                    r_jobs[1].sum_e <= nse;
                    r_jobs[1].sum_n <= nsn;
                    r_jobs[1].last  <= 1'b1;
                    if (r_invalid) begin
                        // out-of-range beam closes the cluster; scan end finds it empty
                        r_jv[0]        <= yield_cur;
                        r_jv[1]        <= 1'b0;
                        r_jobs[0].last <= 1'b1;
                        r_pc <= '0;
                        r_se <= '0;
                        r_sn <= '0;
                    end else begin
                        r_jv[0]        <= split && yield_cur;
                        r_jv[1]        <= r_eos && yield_new;
                        r_jobs[0].last <= !(r_eos && yield_new);
                        r_pe <= r_east;
                        r_pn <= r_north;
                        if (r_eos) begin
                            r_pc <= '0;
                            r_se <= '0;
                            r_sn <= '0;
                        end else begin
                            r_pc <= npc;
                            r_se <= nse;
                            r_sn <= nsn;
                        end
                    end
                    if (r_eos || (r_bc == BW'(MAX_BEAMS - 1))) begin
                        r_bc <= '0;
                    end else begin
                        r_bc <= r_bc + 1'b1;
                    end
                end
                sbc_pkg::F_PUSH: begin
                    if (o_push) begin
                        if (r_jv[0]) begin
                            r_jv[0] <= 1'b0;
                        end else begin
                            r_jv[1] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/sbc_queue.sv @@
// Small job queue between the front and back ends.
module sbc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbc_pkg::t_job i_push_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sbc_pkg::t_job o_job
);
    localparam int AW = $clog2(sbc_pkg::QUEUE_DEPTH);

    sbc_pkg::t_job r_mem [sbc_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW+1)'(sbc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(sbc_pkg::QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

@@ hdl/sbc_back.sv @@
// Back end: centroid vectoring, gain scaling, divide and result register.
module sbc_back #(
    parameter int CORDIC_STEPS = sbc_pkg::DEF_CORDIC_STEPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  sbc_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [15:0]   o_landmark_range,
    output logic signed [15:0] o_landmark_bearing,
    output logic          o_last_of_item
);
    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int DW = $clog2(sbc_pkg::DIV_STEPS + 1);

    sbc_pkg::t_bstate r_state, n_state;

    logic signed [38:0] r_x, r_y;
    logic [31:0]        r_z;
    logic [IW-1:0]      r_i;
    logic [DW-1:0]      r_k;
    logic [10:0]        r_pc;
    logic               r_last;
    logic [62:0]        r_acc;
    logic [30:0]        r_dq;
    logic [10:0]        r_rem;
    logic               r_ovalid;

    logic signed [38:0] xs, ys, x0, y0;
    logic [31:0]        atan_v, zr;
    logic [37:0]        xp;
    logic [62:0]        hi_prod, acc_n;
    logic [11:0]        trial;
    logic               ge;
    logic               load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbc_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            sbc_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = sbc_pkg::B_VEC;
                end
            end
            sbc_pkg::B_VEC: begin
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    n_state = sbc_pkg::B_MUL1;
                end
            end
            sbc_pkg::B_MUL1: n_state = sbc_pkg::B_MUL2;
            sbc_pkg::B_MUL2: n_state = sbc_pkg::B_DIV;
            sbc_pkg::B_DIV: begin
                if (r_k == DW'(sbc_pkg::DIV_STEPS - 1)) begin
                    n_state = sbc_pkg::B_OUT;
                end
            end
            sbc_pkg::B_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = sbc_pkg::B_IDLE;
                end
            end
            default: n_state = sbc_pkg::B_IDLE;
        endcase
    end

    assign x0 = 39'(i_job.sum_e) <<< 8;
    assign y0 = 39'(i_job.sum_n) <<< 8;

    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign atan_v = sbc_pkg::atan_lut(5'(r_i));

    assign xp      = r_x[38] ? 38'd0 : r_x[37:0];
    assign hi_prod = 63'(xp[37:19]) * 63'(sbc_pkg::GAIN_Q24);
    // product plus half the divisor, both scaled by 2^32
    assign acc_n   = r_acc + (hi_prod << 19) + (63'(r_pc) << 31);

    assign trial = {r_rem, r_dq[30]};
    assign ge    = (trial >= {1'b0, r_pc});
    assign zr    = r_z + 32'h00008000;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sbc_pkg::B_IDLE: begin
                if (o_pop) begin
                    r_pc   <= i_job.count;
                    r_last <= i_job.last;
                    r_i    <= '0;
                    if (x0 < 0) begin
                        r_x <= -x0;
                        r_y <= -y0;
                        r_z <= 32'h80000000;
                    end else begin
                        r_x <= x0;
                        r_y <= y0;
                        r_z <= 32'h00000000;
                    end
                end
            end
            sbc_pkg::B_VEC: begin
                if (!r_y[38]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end
                r_i <= r_i + 1'b1;
            end
            sbc_pkg::B_MUL1: begin
                r_acc <= 63'(xp[18:0]) * 63'(sbc_pkg::GAIN_Q24);
            end
            sbc_pkg::B_MUL2: begin
                r_dq  <= acc_n[62:32];
                r_rem <= '0;
                r_k   <= '0;
            end
            sbc_pkg::B_DIV: begin
                r_rem <= ge ? 11'(trial - {1'b0, r_pc}) : trial[10:0];
                r_dq  <= {r_dq[29:0], ge};
                r_k   <= r_k + 1'b1;
            end
            sbc_pkg::B_OUT: begin
                if (load_out) begin
                    o_landmark_range   <= (|r_dq[30:16]) ? 16'hFFFF : r_dq[15:0];
                    o_landmark_bearing <= zr[31:16];
                    o_last_of_item     <= r_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> r_ovalid && $stable(o_landmark_range))
        else $error("stalled result changed");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == sbc_pkg::B_VEC) else $error("pop outside idle");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbc_pkg::B_DIV) |-> r_pc != 11'd0) else $error("divide by zero count");

endmodule

@@ dv/sbc_checker.sv @@
// Checker for the scan beam clusterer: tracks config, predicts landmarks, compares results.
module sbc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [15:0]        i_range_sample,
    input  logic               i_end_of_scan,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [15:0]        i_landmark_range,
    input  logic signed [15:0] i_landmark_bearing,
    input  logic               i_last_of_item,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int ROT_STEPS = sbc_pkg::DEF_CORDIC_STEPS;
    localparam int CLUSTER_LIMIT = 2047;

    localparam logic [31:0] ATAN_ANGLE [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct {
        logic [15:0] rng;
        logic [15:0] brg;
        logic        last;
    } t_landmark;

    t_landmark      landmark_q[$];
    sbc_pkg::t_cfg  cfg;
    int             beam_idx;
    int             pts;
    longint         sum_e, sum_n, prev_e, prev_n;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    // rotation CORDIC: cos/sin of a 16-bit binary angle in Q30
    function automatic void beam_sincos(input logic [15:0] ang, output longint c,
                                        output longint s);
        logic [31:0] z;
        logic        flip;
        longint      x, y, xs, ys;
        z    = {ang, 16'h0000};
        flip = z[31] ^ z[30];
        x    = longint'(sbc_pkg::GAIN_Q30);
        y    = 0;
        if (flip) z = z + 32'h80000000;
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (!z[31]) begin
                x = x - ys; y = y + xs; z = z - ATAN_ANGLE[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_ANGLE[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // centroid of the open cluster as range/bearing, then clear it
    function automatic void close_cluster();
        longint      x, y, xs, ys;
        logic [31:0] z, zr;
        logic [63:0] prod, den, rng;
        t_landmark   lm;
        if (pts > 0 && pts >= int'(cfg.least)) begin
            x = sum_e * 256;
            y = sum_n * 256;
            z = 32'h0;
            if (x < 0) begin
                x = -x; y = -y; z = 32'h80000000;
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z = z + ATAN_ANGLE[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - ATAN_ANGLE[i];
                end
            end
            if (x < 0) x = 0;
            prod = 64'(x) * 64'(sbc_pkg::GAIN_Q24);
            den  = 64'(pts) << 32;
            rng  = (prod + den / 2) / den;
            if (rng > 64'd65535) rng = 64'd65535;
            zr      = z + 32'h8000;
            lm.rng  = rng[15:0];
            lm.brg  = zr[31:16];
            lm.last = 1'b0;
            landmark_q.insert(landmark_q.size(), lm);
        end
        pts   = 0;
        sum_e = 0;
        sum_n = 0;
    endfunction

    function automatic void predict_beam(input logic [15:0] r, input logic eos);
        int          n0;
        logic [31:0] ang;
        longint      c, s, east, north, dx, dy, d2, t2;
        n0 = landmark_q.size();
        if (r < cfg.lower || r > cfg.upper) begin
            close_cluster();
        end else begin
            ang = 32'(cfg.start) + 32'(beam_idx) * 32'(cfg.step);
            beam_sincos(ang[15:0], c, s);
            east  = (longint'(r) * c + (64'sd1 <<< 29)) >>> 30;
            north = (longint'(r) * s + (64'sd1 <<< 29)) >>> 30;
            if (pts > 0) begin
                dx = east - prev_e;
                dy = north - prev_n;
                d2 = dx * dx + dy * dy;
                t2 = longint'(cfg.join_dist) * longint'(cfg.join_dist);
                if (d2 > t2 || pts >= CLUSTER_LIMIT) close_cluster();
            end
            pts++;
            sum_e  = sum_e + east;
            sum_n  = sum_n + north;
            prev_e = east;
            prev_n = north;
        end
        if (eos) begin
            beam_idx = 0;
            close_cluster();
        end else begin
            beam_idx = (beam_idx + 1) % sbc_pkg::DEF_MAX_BEAMS;
        end
        if (landmark_q.size() > n0) landmark_q[landmark_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_landmark exp_lm;
        if (!i_rst_n) begin
            cfg.lower     = 16'd120;
            cfg.upper     = 16'd3500;
            cfg.start     = 16'd0;
            cfg.step      = 16'd182;
            cfg.join_dist = 16'd300;
            cfg.least     = 13'd3;
            beam_idx = 0;
            pts      = 0;
            sum_e = 0; sum_n = 0; prev_e = 0; prev_n = 0;
        end else begin
            if (i_cfg_we) begin
                case (sbc_pkg::t_reg_idx'(i_cfg_index))
                    sbc_pkg::REG_LOWER: cfg.lower     = i_cfg_data;
                    sbc_pkg::REG_UPPER: cfg.upper     = i_cfg_data;
                    sbc_pkg::REG_START: cfg.start     = i_cfg_data;
                    sbc_pkg::REG_STEP:  cfg.step      = i_cfg_data;
                    sbc_pkg::REG_JOIN:  cfg.join_dist = i_cfg_data;
                    sbc_pkg::REG_LEAST: cfg.least     = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (landmark_q.size() == 0) begin
                    report_mismatch("landmark with nothing pending");
                end else begin
                    exp_lm = landmark_q.pop_front();
                    if (i_landmark_range !== exp_lm.rng)
                        report_mismatch($sformatf("range %0d, want %0d",
                                                  i_landmark_range, exp_lm.rng));
                    if (i_landmark_bearing !== exp_lm.brg)
                        report_mismatch($sformatf("bearing %0d, want %0d",
                                                  i_landmark_bearing,
                                                  $signed(exp_lm.brg)));
                    if (i_last_of_item !== exp_lm.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  i_last_of_item, exp_lm.last));
                end
            end
            if (i_in_valid && !i_in_stall) predict_beam(i_range_sample, i_end_of_scan);
        end
        o_pending = landmark_q.size();
    end

endmodule

@@ dv/tb_scan_beam_clusterer.sv @@
// Testbench top for the scan beam clusterer: stimulus, handshake pacing and verdict.
module tb_scan_beam_clusterer;

    localparam int STALL_LIMIT = 4000;  // cycles without any transaction
    localparam int SETTLE      = 100;   // front may still work on a beam with no result
    localparam int LONG_HOLD   = 600;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [15:0]        i_range_sample = '0;
    logic               i_end_of_scan = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [15:0]        o_landmark_range;
    logic signed [15:0] o_landmark_bearing;
    logic               o_last_of_item;

    int fail_count;
    int pending;
    int snd_idle_pct = 0;   // sender gap chance, percent
    int rcv_idle_pct = 0;   // receiver stall chance, percent
    int hold_request = 0;   // long receiver hold, handed to the receiver process
    int hold_left = 0;
    int quiet_cycles = 0;
    int beams_sent;

    scan_beam_clusterer dut (.*);

    sbc_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_range_sample, .i_end_of_scan,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_landmark_range(o_landmark_range), .i_landmark_bearing(o_landmark_bearing),
        .i_last_of_item(o_last_of_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // watchdog: ends the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // offer one beam, with a random gap first; valid stays up after acceptance
    task automatic send_beam(input logic [15:0] r, input logic eos);
        @(negedge i_clk);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_range_sample <= r;
        i_end_of_scan  <= eos;
        do @(posedge i_clk); while (o_in_stall);
        beams_sent++;
    endtask

    // stop offering and wait until every landmark is out and the front is quiet
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] st, input logic [15:0] sp,
                             input logic [15:0] jn, input logic [15:0] lp);
        drain();
        write_reg(sbc_pkg::REG_LOWER, lo);
        write_reg(sbc_pkg::REG_UPPER, hi);
        write_reg(sbc_pkg::REG_START, st);
        write_reg(sbc_pkg::REG_STEP,  sp);
        write_reg(sbc_pkg::REG_JOIN,  jn);
        write_reg(sbc_pkg::REG_LEAST, lp);
    endtask

    // one scan: mostly a smooth range walk (clusters), with jumps and noise beams
    task automatic random_scan(input int nbeams, input int centre);
        int r;
        int pick;
        r = centre;
        for (int k = 0; k < nbeams; k++) begin
            pick = $urandom_range(99);
            if (pick < 6)
                send_beam(16'($urandom_range(65535)), k == nbeams - 1);
            else begin
                if (pick < 14) r = $urandom_range(100, 3600);
                else r = r + $urandom_range(40) - 20;
                if (r < 0) r = 0;
                send_beam(16'(r), k == nbeams - 1);
            end
        end
    endtask

    task automatic random_config();
        configure(16'($urandom_range(0, 300)), 16'($urandom_range(2500, 65535)),
                  16'($urandom), 16'($urandom_range(0, 400)),
                  16'($urandom_range(40, 600)), 16'($urandom_range(1, 5)));
    endtask

    task automatic random_run(input int items);
        int first;
        first = beams_sent;
        while (beams_sent - first < items) begin
            if ($urandom_range(3) == 0) random_config();
            random_scan($urandom_range(4, 60), $urandom_range(200, 3000));
        end
    endtask

    initial begin
        beams_sent = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config, range limits at both edges, end of scan alone
        send_beam(16'd0, 1'b0);
        send_beam(16'd65535, 1'b0);
        send_beam(16'd120, 1'b0);
        send_beam(16'd3500, 1'b0);
        repeat (5) send_beam(16'd1000, 1'b0);
        send_beam(16'd1000, 1'b1);
        send_beam(16'd5, 1'b1);

        // widest window, least points zero: zero centroid, then a cluster due west
        configure(16'd0, 16'd65535, 16'h8000, 16'd0, 16'd65535, 16'd0);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0000);
        send_beam(16'd0, 1'b0);
        send_beam(16'd0, 1'b1);
        repeat (3) send_beam(16'd65535, 1'b0);
        send_beam(16'd65535, 1'b1);

        // zero join distance: each beam its own cluster and landmark
        configure(16'd0, 16'd65535, 16'h7FFF, 16'hFFFF, 16'd0, 16'd1);
        send_beam(16'd700, 1'b0);
        send_beam(16'd1400, 1'b0);
        send_beam(16'd2100, 1'b1);
        send_beam(16'd32768, 1'b1);

        // large least points: clusters are dropped
        configure(16'd100, 16'd4000, 16'd0, 16'd182, 16'd300, 16'd4096);
        repeat (6) send_beam(16'd1500, 1'b0);
        send_beam(16'd1500, 1'b1);

        // receiver away for a long stretch; one landmark per beam fills the block
        configure(16'd0, 16'd65535, 16'd0, 16'd182, 16'd0, 16'd1);
        hold_request = LONG_HOLD;
        for (int k = 0; k < 40; k++) send_beam(16'd1000, k == 39);
        drain();

        // random, sender mostly busy, receiver mostly stalled
        snd_idle_pct = 18;
        rcv_idle_pct = 87;
        random_config();
        random_run(210);

        snd_idle_pct = 87;
        rcv_idle_pct = 18;
        random_config();
        random_run(210);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_config();
        random_run(210);

        drain();
        repeat (200) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sbc_pkg.sv
hdl/sbc_front.sv
hdl/sbc_queue.sv
hdl/sbc_back.sv
hdl/scan_beam_clusterer.sv
dv/sbc_checker.sv
dv/tb_scan_beam_clusterer.sv
